@@ rtl/brabd_pkg.sv @@
package brabd_pkg;

  // Probability scale of the adaptive model.
  localparam int PROB_BITS = 11;
  localparam logic [PROB_BITS:0] PROB_SCALE = (PROB_BITS + 1)'(1) << PROB_BITS;
  localparam int ADAPT_SHIFT = 5;

  // Bit reader limits.
  localparam logic [4:0] TAKE_MAX     = 5'd24;
  localparam logic [6:0] PUSH_LIMIT   = 7'd56;
  localparam logic [6:0] BYTE_BITS    = 7'd8;
  localparam logic [6:0] SEED_BITS    = 7'd32;
  localparam logic [2:0] SEED_BYTES   = 3'd4;
  localparam logic [31:0] LEN_INIT    = 32'hFFFF_FFFF;

  // Command codes of an input item.
  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_GET    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_DROP   = 3'd3,
    CMD_ALIGN  = 3'd4,
    CMD_REMOVE = 3'd5,
    CMD_START  = 3'd6,
    CMD_DECODE = 3'd7
  } cmd_t;

  // Status codes of a result item.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    DP_IDLE,
    DP_EXEC,
    DP_LATCH,
    DP_TAKE,
    DP_SEED,
    DP_MUL,
    DP_UPD
  } dp_op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_TAKE,
    S_SEED,
    S_MUL,
    S_UPD
  } fsm_state_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       long_go;
    logic       start_cmd;
    logic [2:0] take_cnt;
    logic [6:0] held;
  } dp_stat_t;

endpackage

@@ rtl/brabd_datapath.sv @@
module brabd_datapath
  import brabd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_op_t               op,
  input  logic [2:0]           cmd,
  input  logic [7:0]           byte_in,
  input  logic [4:0]           bit_count,
  input  logic [10:0]          prob_in,
  input  logic                 cfg_we,
  input  logic                 cfg_data,
  output dp_stat_t             stat,
  output logic [23:0]          value,
  output logic                 bit_res,
  output logic [10:0]          prob_out,
  output logic [1:0]           status
);

  // Architectural state.
  logic [63:0] bit_buffer, bit_buffer_next;
  logic [6:0]  bits_held, bits_held_next;
  logic [31:0] range_value, range_value_next;
  logic [31:0] range_length, range_length_next;
  logic        stream_final;

  // Working registers of a decode.
  logic [PROB_BITS-1:0] prob_q;
  logic [31:0]          prod;

  // Result register.
  logic [23:0]          res_value, res_value_next;
  logic                 res_bit, res_bit_next;
  logic [10:0]          res_prob, res_prob_next;
  logic [1:0]           res_status, res_status_next;

  cmd_t        cmd_c;
  logic [4:0]  n;
  logic [6:0]  n7;
  logic        can_take_n;
  logic [6:0]  pad_held;
  logic [23:0] top_bits;
  logic [4:0]  sh;
  logic [63:0] shifted;
  logic [2:0]  k;
  logic [6:0]  k_bits;
  logic [6:0]  drop_n;
  logic [PROB_BITS:0] p_sat, p_up, p_dn, p_new, p_clamp;
  logic        dec_bit;
  logic [31:0] len_sh;

  assign cmd_c = cmd_t'(cmd);

  // Clamp the bit count and work out the padded fill for get and peek.
  assign n          = (bit_count > TAKE_MAX) ? TAKE_MAX : bit_count;
  assign n7         = {2'b00, n};
  assign can_take_n = (bits_held >= n7) || stream_final;
  assign pad_held   = (bits_held >= n7) ? bits_held : n7 + ((bits_held - n7) & 7'd7);
  assign top_bits   = bit_buffer[63:40] >> (TAKE_MAX - n);
  assign drop_n     = (n7 > bits_held) ? bits_held : n7;

  // Leading zero bytes of the length give the renormalization byte count.
  always_comb begin
    if (range_length[31:24] != 8'd0) begin
      k = 3'd0;
    end else if (range_length[23:16] != 8'd0) begin
      k = 3'd1;
    end else if (range_length[15:8] != 8'd0) begin
      k = 3'd2;
    end else if (range_length[7:0] != 8'd0) begin
      k = 3'd3;
    end else begin
      k = 3'd4;
    end
  end
  assign k_bits = {1'b0, k, 3'b000};

  // Status toward the controller.
  always_comb begin
    stat.start_cmd = (cmd_c == CMD_START);
    stat.held      = bits_held;
    stat.take_cnt  = (cmd_c == CMD_START) ? SEED_BYTES : k;
    stat.long_go   = ((cmd_c == CMD_START) && ((bits_held >= SEED_BITS) || stream_final)) ||
                     ((cmd_c == CMD_DECODE) && ((bits_held >= k_bits) || stream_final));
  end

  // Shift amount for the short commands.
  always_comb begin
    case (cmd_c)
      CMD_GET:    sh = n;
      CMD_DROP:   sh = drop_n[4:0];
      CMD_ALIGN:  sh = {2'b00, bits_held[2:0]};
      CMD_REMOVE: sh = 5'd8;
      default:    sh = 5'd0;
    endcase
  end
  assign shifted = bit_buffer << sh;

  // Probability saturation, adaptation and clamp.
  assign p_sat   = ({1'b0, prob_in} >= PROB_SCALE) ? PROB_SCALE - 1'b1 : {1'b0, prob_in};
  assign len_sh  = range_length >> PROB_BITS;
  assign dec_bit = (range_value >= prod);
  assign p_up    = {1'b0, prob_q} + ((PROB_SCALE - {1'b0, prob_q}) >> ADAPT_SHIFT);
  assign p_dn    = {1'b0, prob_q} - ({1'b0, prob_q} >> ADAPT_SHIFT);
  assign p_new   = dec_bit ? p_dn : p_up;
  always_comb begin
    if (p_new < (PROB_BITS + 1)'(1)) begin
      p_clamp = (PROB_BITS + 1)'(1);
    end else if (p_new >= PROB_SCALE) begin
      p_clamp = PROB_SCALE - 1'b1;
    end else begin
      p_clamp = p_new;
    end
  end

  // Next state and result per operation.
  always_comb begin
    bit_buffer_next   = bit_buffer;
    bits_held_next    = bits_held;
    range_value_next  = range_value;
    range_length_next = range_length;
    res_value_next    = res_value;
    res_bit_next      = res_bit;
    res_prob_next     = res_prob;
    res_status_next   = res_status;
    unique case (op)
      DP_EXEC: begin
        res_value_next  = 24'd0;
        res_bit_next    = 1'b0;
        res_prob_next   = 11'd0;
        res_status_next = ST_OK;
        case (cmd_c)
          CMD_PUSH: begin
            if (bits_held > PUSH_LIMIT) begin
              res_status_next = ST_FULL;
            end else begin
              bit_buffer_next = bit_buffer | ({byte_in, 56'd0} >> bits_held);
              bits_held_next  = bits_held + BYTE_BITS;
            end
          end
          CMD_GET, CMD_PEEK: begin
            if (!can_take_n) begin
              res_status_next = ST_SHORT;
            end else begin
              res_value_next = top_bits;
              if (cmd_c == CMD_GET) begin
                bit_buffer_next = shifted;
                bits_held_next  = pad_held - n7;
              end else begin
                bits_held_next = pad_held;
              end
            end
          end
          CMD_DROP: begin
            bit_buffer_next = shifted;
            bits_held_next  = bits_held - drop_n;
          end
          CMD_ALIGN: begin
            bit_buffer_next = shifted;
            bits_held_next  = bits_held - {4'd0, bits_held[2:0]};
          end
          CMD_REMOVE: begin
            if (bits_held < BYTE_BITS) begin
              res_status_next = ST_SHORT;
            end else begin
              res_value_next  = {16'd0, bit_buffer[63:56]};
              bit_buffer_next = shifted;
              bits_held_next  = bits_held - BYTE_BITS;
            end
          end
          default: begin
            // Start or decode reach here only when starved.
            res_status_next = ST_SHORT;
          end
        endcase
      end
      DP_TAKE: begin
        // One byte into the decoder; missing bits read as zero.
        range_value_next  = {range_value[23:0], bit_buffer[63:56]};
        range_length_next = range_length << 8;
        bit_buffer_next   = bit_buffer << 8;
        bits_held_next    = (bits_held >= BYTE_BITS) ? bits_held - BYTE_BITS : bits_held;
      end
      DP_SEED: begin
        range_length_next = LEN_INIT;
        res_value_next    = 24'd0;
        res_bit_next      = 1'b0;
        res_prob_next     = 11'd0;
        res_status_next   = ST_OK;
      end
      DP_UPD: begin
        if (dec_bit) begin
          range_value_next  = range_value - prod;
          range_length_next = range_length - prod;
        end else begin
          range_length_next = prod;
        end
        res_value_next  = 24'd0;
        res_bit_next    = dec_bit;
        res_prob_next   = p_clamp[10:0];
        res_status_next = ST_OK;
      end
      DP_IDLE, DP_LATCH, DP_MUL: begin
      end
      default: begin
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buffer   <= 64'd0;
      bits_held    <= 7'd0;
      range_value  <= 32'd0;
      range_length <= 32'd0;
      stream_final <= 1'b0;
    end else begin
      bit_buffer   <= bit_buffer_next;
      bits_held    <= bits_held_next;
      range_value  <= range_value_next;
      range_length <= range_length_next;
      if (cfg_we) begin
        stream_final <= cfg_data;
      end
    end
  end

  // Payload registers: probability, product and result.
  always_ff @(posedge clk) begin
    if (op == DP_LATCH) begin
      prob_q <= p_sat[PROB_BITS-1:0];
    end
    if (op == DP_MUL) begin
      prod <= 32'({{(32 - PROB_BITS){1'b0}}, prob_q} * len_sh);
    end
    res_value  <= res_value_next;
    res_bit    <= res_bit_next;
    res_prob   <= res_prob_next;
    res_status <= res_status_next;
  end

  assign value    = res_value;
  assign bit_res  = res_bit;
  assign prob_out = res_prob;
  assign status   = res_status;

endmodule

@@ rtl/brabd_ctrl.sv @@
module brabd_ctrl
  import brabd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output logic     in_ready,
  output logic     out_valid,
  output dp_op_t   op
);

  fsm_state_t state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       is_start, is_start_next;
  logic       out_valid_q, out_valid_next;
  logic       load;

  // Accept while idle and the result slot is free or being emptied.
  assign in_ready  = (state == S_IDLE) && (!out_valid_q || out_ready);
  assign out_valid = out_valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    is_start_next = is_start;
    op            = DP_IDLE;
    load          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          if (stat.long_go) begin
            op            = DP_LATCH;
            cnt_next      = stat.take_cnt;
            is_start_next = stat.start_cmd;
            state_next    = (stat.take_cnt == 3'd0) ? S_MUL : S_TAKE;
          end else begin
            op   = DP_EXEC;
            load = 1'b1;
          end
        end
      end
      S_TAKE: begin
        op       = DP_TAKE;
        cnt_next = cnt - 3'd1;
        if (cnt == 3'd1) begin
          state_next = is_start ? S_SEED : S_MUL;
        end
      end
      S_SEED: begin
        op         = DP_SEED;
        load       = 1'b1;
        state_next = S_IDLE;
      end
      S_MUL: begin
        op         = DP_MUL;
        state_next = S_UPD;
      end
      S_UPD: begin
        op         = DP_UPD;
        load       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_valid_q && out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid_q;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= 3'd0;
      is_start    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      is_start    <= is_start_next;
      out_valid_q <= out_valid_next;
    end
  end

endmodule

@@ rtl/bit_reader_arith_bit_decoder_unit.sv @@
// Bit reader with an adaptive binary range decoder.
// The input channel (in_valid/in_ready) carries one item: cmd, byte_in,
// bit_count and prob_in. The output channel (out_valid/out_ready) returns
// exactly one result item per input item: value, bit_res, prob_out, status.
// Push, get, peek, drop, align and remove byte, and any starved command,
// finish in the cycle of acceptance; the result is valid on the next cycle.
// Decoder start runs through acceptance, four byte steps and the length
// seed. Decode bit runs through acceptance, k byte steps, where k (0 to 4)
// is the number of renormalization bytes and one byte moves per cycle,
// then the probability multiply is registered before the compare and update.
// A new item is accepted while the block is idle and the result register is
// empty or being read in the same cycle, so short commands run one per cycle.
// When the receiver stalls, the result holds and the next item waits.
// Reset (rst, synchronous) empties the bit buffer, zeroes the decoder state,
// clears stream_final and drops any pending result.
// cfg_we with cfg_data writes stream_final; write it only while idle.
module bit_reader_arith_bit_decoder_unit
  import brabd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  cmd,
  input  logic [7:0]  byte_in,
  input  logic [4:0]  bit_count,
  input  logic [10:0] prob_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] value,
  output logic        bit_res,
  output logic [10:0] prob_out,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic        cfg_data
);

  dp_stat_t stat;
  dp_op_t   dp_op;

  // Sequencer.
  brabd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .op        (dp_op)
  );

  // Bit buffer, decoder state and result register.
  brabd_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (dp_op),
    .cmd       (cmd),
    .byte_in   (byte_in),
    .bit_count (bit_count),
    .prob_in   (prob_in),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .value     (value),
    .bit_res   (bit_res),
    .prob_out  (prob_out),
    .status    (status)
  );

  // A new item is taken only when its result has a free slot.
  a_ready_slot: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("input accepted while the result slot is blocked");

  // The buffer never holds more than 64 bits.
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    stat.held <= 7'd64)
    else $error("bit count of the buffer out of range");

  // Byte steps lead only to more steps, the seed or the multiply.
  a_take_seq: assert property (@(posedge clk) disable iff (rst)
    (dp_op == DP_TAKE) |=> (dp_op == DP_TAKE || dp_op == DP_SEED || dp_op == DP_MUL))
    else $error("byte step left the decode sequence");

  // The multiply is always followed by the update.
  a_mul_upd: assert property (@(posedge clk) disable iff (rst)
    (dp_op == DP_MUL) |=> (dp_op == DP_UPD))
    else $error("update did not follow the multiply");

endmodule
